/* sv/battery_runtime_estimator_unit_assert.svh */
// Assertion macros used by the estimator checker.
`ifndef BATTERY_RUNTIME_ESTIMATOR_UNIT_ASSERT_SVH
`define BATTERY_RUNTIME_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BRE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("estimator check failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define BRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("estimator check failed (next cycle)");

`endif

/* sv/bre_pkg.sv */
// Shared constants, types and helpers for the battery runtime estimator.
package bre_pkg;

  localparam int AGE_W    = 20;
  localparam int CHARGE_W = 7;
  localparam int TIME_W   = 32;
  localparam int REMAIN_W = 24;
  localparam int TENTHS_W = 4;

  localparam logic [AGE_W-1:0]    MAX_AGE_RESET = 20'd86400;
  localparam logic [CHARGE_W-1:0] FULL_CHARGE   = 7'd100;
  localparam logic [CHARGE_W-1:0] DROP_STEP     = 7'd10;

  // charge / 10 as (charge * 205) >> 11, exact for every 7-bit charge
  localparam logic [7:0] TENTHS_MUL   = 8'd205;
  localparam int         TENTHS_SHIFT = 11;

  typedef struct packed {
    logic record;
    logic persist;
    logic full_known;
  } flags_t;

  function automatic logic [TENTHS_W-1:0] charge_tenths(input logic [CHARGE_W-1:0] c);
    logic [CHARGE_W+7:0] p;
    p = {8'd0, c} * {7'd0, TENTHS_MUL};
    return p[TENTHS_SHIFT +: TENTHS_W];
  endfunction

endpackage

/* sv/bre_ring.sv */
// Drop-interval ring memory with registered read and per-entry fill bits.
module bre_ring import bre_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int HW    = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [HW-1:0]    wr_addr,
  input  logic [AGE_W-1:0] wr_data,
  input  logic [HW-1:0]    rd_addr,
  output logic [AGE_W-1:0] rd_data
);

  logic [AGE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] filled;
  logic [AGE_W-1:0] rd_word;
  logic             rd_filled;
  logic             rd_hit;

  assign rd_hit = wr_en && (rd_addr == wr_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_hit) begin
      rd_word <= wr_data;
    end else begin
      rd_word <= mem[rd_addr];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      rd_filled <= rd_hit || filled[rd_addr];
    end
  end

  assign rd_data = rd_filled ? rd_word : '0;

endmodule

/* sv/bre_update.sv */
// Sample decision logic and stored battery state; registers the stage B payload.
module bre_update import bre_pkg::*; #(
  parameter int RING_DEPTH = 8,
  parameter int HW         = 3,
  parameter int SUM_W      = 23
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [AGE_W-1:0]    max_age,
  input  logic [CHARGE_W-1:0] charge,
  input  logic                charging,
  input  logic                plugged,
  input  logic [TIME_W-1:0]   now,
  output logic [SUM_W-1:0]    b_sum,
  output logic [TENTHS_W-1:0] b_tenths,
  output logic [TIME_W-1:0]   b_since,
  output flags_t              b_flags
);

  localparam logic [HW-1:0] LAST_SLOT = HW'(RING_DEPTH - 1);

  logic [SUM_W-1:0]    interval_sum;
  logic [HW-1:0]       ring_head;
  logic [CHARGE_W-1:0] last_charge;
  logic                last_charging;
  logic                last_plugged;
  logic [TIME_W-1:0]   last_change_time;
  logic [TIME_W-1:0]   full_unplug_time;
  logic                full_time_known;

  logic [TIME_W-1:0]   age;
  logic                drop_ok;
  logic                record;
  logic                full_unplug;
  logic                changed;
  logic [HW-1:0]       head_step;
  logic [HW-1:0]       head_after;
  logic [HW-1:0]       rd_addr;
  logic [AGE_W-1:0]    old_interval;
  logic [SUM_W-1:0]    interval_sum_next;
  logic                known_after;
  logic [TIME_W-1:0]   since;

  always_comb begin
    age     = now - last_change_time;
    drop_ok = (last_charge >= DROP_STEP) && (charge == last_charge - DROP_STEP);
    record  = !(charging || last_charging || plugged || last_plugged) && drop_ok &&
              (age < TIME_W'(max_age));
    head_step  = (ring_head == LAST_SLOT) ? '0 : ring_head + HW'(1);
    head_after = (fire && record) ? head_step : ring_head;
    // prefetch the slot the next recording will overwrite
    rd_addr    = (head_after == LAST_SLOT) ? '0 : head_after + HW'(1);
    interval_sum_next = interval_sum - SUM_W'(old_interval) + SUM_W'(age[AGE_W-1:0]);
    full_unplug = last_plugged && (last_charge == FULL_CHARGE) && !plugged &&
                  (charge == FULL_CHARGE);
    changed     = (charge != last_charge) || (charging != last_charging) ||
                  (plugged != last_plugged);
    known_after = full_time_known || full_unplug;
    if (!known_after) begin
      since = '0;
    end else if (full_unplug) begin
      since = '0;
    end else begin
      since = now - full_unplug_time;
    end
  end

  bre_ring #(
    .DEPTH (RING_DEPTH),
    .HW    (HW)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire && record),
    .wr_addr (head_step),
    .wr_data (age[AGE_W-1:0]),
    .rd_addr (rd_addr),
    .rd_data (old_interval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_sum     <= '0;
      ring_head        <= '0;
      last_charge      <= '0;
      last_charging    <= 1'b0;
      last_plugged     <= 1'b0;
      last_change_time <= '0;
      full_time_known  <= 1'b0;
    end else if (fire) begin
      if (record) begin
        interval_sum <= interval_sum_next;
        ring_head    <= head_step;
      end
      if (full_unplug) begin
        full_time_known <= 1'b1;
      end
      if (changed) begin
        last_charge      <= charge;
        last_charging    <= charging;
        last_plugged     <= plugged;
        last_change_time <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && full_unplug) begin
      full_unplug_time <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_sum              <= record ? interval_sum_next : interval_sum;
      b_tenths           <= charge_tenths(charge);
      b_since            <= since;
      b_flags.record     <= record;
      b_flags.persist    <= record || full_unplug || changed;
      b_flags.full_known <= known_after;
    end
  end

endmodule

/* sv/bre_estimate.sv */
// Mean interval by reciprocal multiply, then runtime product into the result register.
module bre_estimate import bre_pkg::*; #(
  parameter int RING_DEPTH = 8,
  parameter int SUM_W      = 23
) (
  input  logic                clk,
  input  logic                c_load,
  input  logic                out_load,
  input  logic [SUM_W-1:0]    b_sum,
  input  logic [TENTHS_W-1:0] b_tenths,
  input  logic [TIME_W-1:0]   b_since,
  input  flags_t              b_flags,
  output logic [REMAIN_W-1:0] remaining_seconds,
  output logic [TIME_W-1:0]   since_full_seconds,
  output logic                since_full_valid,
  output logic                interval_recorded,
  output logic                needs_persist
);

  // floor(x / D) = (x * ceil(2^S / D)) >> S for every SUM_W-bit x
  localparam int          SHIFT      = SUM_W + $clog2(RING_DEPTH);
  localparam int          RECIP_W    = SUM_W + 1;
  localparam int          PROD_W     = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) /
                                       64'(RING_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [PROD_W-1:0]   mean_prod;
  logic [AGE_W-1:0]    c_mean;
  logic [TENTHS_W-1:0] c_tenths;
  logic [TIME_W-1:0]   c_since;
  flags_t              c_flags;

  assign mean_prod = PROD_W'(b_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_mean   <= mean_prod[SHIFT +: AGE_W];
      c_tenths <= b_tenths;
      c_since  <= b_since;
      c_flags  <= b_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      remaining_seconds  <= REMAIN_W'(c_tenths) * REMAIN_W'(c_mean);
      since_full_seconds <= c_since;
      since_full_valid   <= c_flags.full_known;
      interval_recorded  <= c_flags.record;
      needs_persist      <= c_flags.persist;
    end
  end

endmodule

/* sv/battery_runtime_estimator_unit.sv */
// Top level of the battery runtime estimator: channels, pipeline control, config register.
//
// Usage:
//   Sample channel: charge_level, charging_now, plugged_in, now_seconds, qualified by
//   sample_valid; a request is taken at a clock edge with sample_valid high and
//   sample_stall low. Result channel: one result per sample, shown with result_valid
//   and taken when result_stall is low.
//   Config: cfg_wen writes cfg_wdata into max_age_seconds at that edge; write only
//   while the block holds no request in flight.
//   Path: after its sample is taken, a result passes the state update into stage B, the
//   mean multiply into stage C and the runtime multiply into the result register.
//   Throughput: one sample per cycle while sample_stall stays low; each stage carries its
//   own valid bit, so a waiting result does not block samples behind it until the pipeline is full.
//   The rate is set by the state update loop (age check, ring slot, running sum), which
//   closes within stage A.
//   Stall: a stalled result holds its value; stages fill behind it, and sample_stall
//   rises only when the input register cannot move on.
//   Reset (rst, synchronous): pipeline empties, stored state and ring clear,
//   max_age_seconds returns to 86400. No clearing pass: the ring has per-slot fill bits.
module battery_runtime_estimator_unit import bre_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [CHARGE_W-1:0] charge_level,
  input  logic                charging_now,
  input  logic                plugged_in,
  input  logic [TIME_W-1:0]   now_seconds,
  input  logic                cfg_wen,
  input  logic [AGE_W-1:0]    cfg_wdata,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [REMAIN_W-1:0] remaining_seconds,
  output logic [TIME_W-1:0]   since_full_seconds,
  output logic                since_full_valid,
  output logic                interval_recorded,
  output logic                needs_persist
);

  localparam int HW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  // running sum holds up to RING_DEPTH full 20-bit intervals
  localparam int SUM_W = AGE_W + $clog2(RING_DEPTH);

  logic [AGE_W-1:0]    max_age_seconds;

  // stage valid bits
  logic a_valid;
  logic b_valid;
  logic c_valid;

  // handshake between stages
  logic out_ready;
  logic c_ready;
  logic b_ready;
  logic a_ready;
  logic a_load;
  logic a_fire;
  logic b_fire;
  logic c_fire;

  // input register
  logic [CHARGE_W-1:0] a_charge;
  logic                a_charging;
  logic                a_plugged;
  logic [TIME_W-1:0]   a_now;

  // stage B payload
  logic [SUM_W-1:0]    b_sum;
  logic [TENTHS_W-1:0] b_tenths;
  logic [TIME_W-1:0]   b_since;
  flags_t              b_flags;

  always_comb begin
    out_ready    = !result_valid || !result_stall;
    c_ready      = !c_valid || out_ready;
    b_ready      = !b_valid || c_ready;
    a_ready      = !a_valid || b_ready;
    a_load       = sample_valid && a_ready;
    a_fire       = a_valid && b_ready;
    b_fire       = b_valid && c_ready;
    c_fire       = c_valid && out_ready;
    sample_stall = !a_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age_seconds <= MAX_AGE_RESET;
    end else if (cfg_wen) begin
      max_age_seconds <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
      if (a_fire) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        c_valid <= 1'b1;
      end else if (c_fire) begin
        c_valid <= 1'b0;
      end
      if (c_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_charge   <= charge_level;
      a_charging <= charging_now;
      a_plugged  <= plugged_in;
      a_now      <= now_seconds;
    end
  end

  // stage A: decisions and stored state, commits when the request moves to B
  bre_update #(
    .RING_DEPTH (RING_DEPTH),
    .HW         (HW),
    .SUM_W      (SUM_W)
  ) u_update (
    .clk      (clk),
    .rst      (rst),
    .fire     (a_fire),
    .max_age  (max_age_seconds),
    .charge   (a_charge),
    .charging (a_charging),
    .plugged  (a_plugged),
    .now      (a_now),
    .b_sum    (b_sum),
    .b_tenths (b_tenths),
    .b_since  (b_since),
    .b_flags  (b_flags)
  );

  // stages B and C: mean interval, then runtime estimate
  bre_estimate #(
    .RING_DEPTH (RING_DEPTH),
    .SUM_W      (SUM_W)
  ) u_estimate (
    .clk                (clk),
    .c_load             (b_fire),
    .out_load           (c_fire),
    .b_sum              (b_sum),
    .b_tenths           (b_tenths),
    .b_since            (b_since),
    .b_flags            (b_flags),
    .remaining_seconds  (remaining_seconds),
    .since_full_seconds (since_full_seconds),
    .since_full_valid   (since_full_valid),
    .interval_recorded  (interval_recorded),
    .needs_persist      (needs_persist)
  );

endmodule

/* sv/bre_checker.sv */
// Port-level checker for the battery runtime estimator, bound to the top level.
`include "battery_runtime_estimator_unit_assert.svh"

module bre_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [23:0] remaining_seconds,
  input logic [31:0] since_full_seconds,
  input logic        since_full_valid,
  input logic        interval_recorded,
  input logic        needs_persist
);

  // a stalled result keeps its value
  `BRE_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(remaining_seconds) && $stable(since_full_seconds))

  // with no result waiting the pipeline always drains, so samples are never held off
  `BRE_ASSERT_NOW(a_no_stall_when_empty, clk, rst, !result_valid, !sample_stall)

  // a recorded interval changes stored state
  `BRE_ASSERT_NOW(a_record_persists, clk, rst, result_valid && interval_recorded,
    needs_persist)

  // elapsed time reads zero until a full-charge unplug is known
  `BRE_ASSERT_NOW(a_since_zero, clk, rst, result_valid && !since_full_valid,
    since_full_seconds == 32'd0)

endmodule

bind battery_runtime_estimator_unit bre_checker u_bre_checker (
  .clk                (clk),
  .rst                (rst),
  .sample_stall       (sample_stall),
  .result_valid       (result_valid),
  .result_stall       (result_stall),
  .remaining_seconds  (remaining_seconds),
  .since_full_seconds (since_full_seconds),
  .since_full_valid   (since_full_valid),
  .interval_recorded  (interval_recorded),
  .needs_persist      (needs_persist)
);
